FILE: hdl/alif_pkg.sv
// alif_pkg: shared constants, register codes and structs for the adaptive LIF neuron block
// no dependencies; imported by every module under hdl
`default_nettype none

package alif_pkg;

    // default sizes of the neuron state
    localparam int NEURON_COUNT_DEF = 256;
    localparam int STATE_WIDTH_DEF  = 24;

    // fixed field widths
    localparam int IDX_W   = 8;
    localparam int CUR_W   = 16;
    localparam int CFG_W   = 16;
    localparam int SUM_W   = 24;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // result buffer
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;

    // register reset values
    localparam logic [CFG_W-1:0] MEMBRANE_DECAY_RST   = 16'd62259;
    localparam logic [CFG_W-1:0] ADAPTATION_DECAY_RST = 16'd65208;
    localparam logic [CFG_W-1:0] ADAPTATION_GAIN_RST  = 16'd256;
    localparam logic [CFG_W-1:0] REST_THRESHOLD_RST   = 16'd256;

    // register codes, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_MEMBRANE_DECAY   = 2'd0,
        REG_ADAPTATION_DECAY = 2'd1,
        REG_ADAPTATION_GAIN  = 2'd2,
        REG_REST_THRESHOLD   = 2'd3
    } reg_idx_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic        [CFG_W-1:0] membrane_decay;
        logic        [CFG_W-1:0] adaptation_decay;
        logic signed [CFG_W-1:0] adaptation_gain;
        logic signed [CFG_W-1:0] rest_threshold;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic        [IDX_W-1:0] neuron_index;
        logic                    spike;
        logic signed [SUM_W-1:0] trace_sum;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/alif_neuron_eprop_update.sv
// Path: state memory read, first stage, second stage (products), then the result buffer.
// Throughput: one neuron step per cycle through the state memory's read-modify-write
//   while the input is not held: consecutive steps of the same neuron stall
//   (read-after-write), and no word is accepted while all result slots are reserved.
// Reset: registers return to their reset values; the state memory is then swept
//   to zero, one entry a cycle, and no word is accepted meanwhile.
`default_nettype none

module alif_neuron_eprop_update #(
    parameter int NEURON_COUNT = alif_pkg::NEURON_COUNT_DEF,
    parameter int STATE_WIDTH  = alif_pkg::STATE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [alif_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [alif_pkg::PDATA_W-1:0]   pwdata,
    output logic      [alif_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    // step channel
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [alif_pkg::IDX_W-1:0]     neuron_index,
    input  wire logic [alif_pkg::CUR_W-1:0]     input_current,
    input  wire logic                           sequence_start,
    // result channel
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic      [alif_pkg::IDX_W-1:0]     out_neuron_index,
    output logic                                spike,
    output logic      [alif_pkg::SUM_W-1:0]     trace_sum
);
    import alif_pkg::*;

    localparam int ADDR_W   = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
    localparam int WORD_W   = 4 * STATE_WIDTH + 1;
    localparam int IDX_SPAN = 1 << IDX_W;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic               cfg_write;
    reg_idx_t           reg_sel;
    logic [OUT_PTR_W:0] inflight_reg;
    logic [OUT_PTR_W:0] inflight_next;

    logic [ADDR_W-1:0] idx_map [IDX_SPAN];
    logic [ADDR_W-1:0] step_addr;
    logic              accept;
    logic              deliver;
    logic              clearing;
    logic              hazard;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              res_valid;
    result_t           res;
    result_t           out_word;

    // index to entry, folded modulo the neuron count
    for (genvar k = 0; k < IDX_SPAN; k++)
    begin : g_idx_map
        assign idx_map[k] = ADDR_W'(k % NEURON_COUNT);
    end
    assign step_addr = idx_map[neuron_index];

    // configuration registers
    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            REG_MEMBRANE_DECAY:
            begin
                cfg_next.membrane_decay = pwdata[CFG_W-1:0];
                prdata[CFG_W-1:0]       = cfg_reg.membrane_decay;
            end
            REG_ADAPTATION_DECAY:
            begin
                cfg_next.adaptation_decay = pwdata[CFG_W-1:0];
                prdata[CFG_W-1:0]         = cfg_reg.adaptation_decay;
            end
            REG_ADAPTATION_GAIN:
            begin
                cfg_next.adaptation_gain = $signed(pwdata[CFG_W-1:0]);
                prdata[CFG_W-1:0]        = cfg_reg.adaptation_gain;
            end
            REG_REST_THRESHOLD:
            begin
                cfg_next.rest_threshold = $signed(pwdata[CFG_W-1:0]);
                prdata[CFG_W-1:0]       = cfg_reg.rest_threshold;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.membrane_decay   <= MEMBRANE_DECAY_RST;
            cfg_reg.adaptation_decay <= ADAPTATION_DECAY_RST;
            cfg_reg.adaptation_gain  <= ADAPTATION_GAIN_RST;
            cfg_reg.rest_threshold   <= REST_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            cfg_reg <= cfg_next;
        end
    end

    // words in flight, each holding a reserved result slot
    assign accept        = item_valid && item_ready;
    assign deliver       = result_valid && result_ready;
    assign item_ready    = !clearing && !hazard
                           && (inflight_reg != (OUT_PTR_W+1)'(OUT_DEPTH));
    assign inflight_next = inflight_reg + {{OUT_PTR_W{1'b0}}, accept}
                           - {{OUT_PTR_W{1'b0}}, deliver};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    alif_state_mem #(
        .NEURON_COUNT (NEURON_COUNT),
        .WORD_W       (WORD_W),
        .ADDR_W       (ADDR_W)
    ) u_state_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (step_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    alif_update #(
        .STATE_WIDTH (STATE_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_update (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .accept         (accept),
        .neuron_index   (neuron_index),
        .input_current  (input_current),
        .sequence_start (sequence_start),
        .addr           (step_addr),
        .rd_data        (rd_data),
        .hazard         (hazard),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .res_valid      (res_valid),
        .res            (res)
    );

    alif_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .valid     (result_valid),
        .ready     (result_ready),
        .data      (out_word)
    );

    assign out_neuron_index = out_word.neuron_index;
    assign spike            = out_word.spike;
    assign trace_sum        = out_word.trace_sum;

`ifndef ASSERT_OFF
    // a waiting result always belongs to a counted word
    a_result_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> inflight_reg != '0)
        else $error("result without a word in flight");
`endif

endmodule

`default_nettype wire

FILE: hdl/alif_state_mem.sv
// alif_state_mem: per-neuron state memory, one write and one registered read port
// sweeps all entries to zero after reset; uses alif_pkg
`default_nettype none

module alif_state_mem #(
    parameter int NEURON_COUNT = alif_pkg::NEURON_COUNT_DEF,
    parameter int WORD_W       = 4 * alif_pkg::STATE_WIDTH_DEF + 1,
    parameter int ADDR_W       = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WORD_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    output logic                   clearing
);
    import alif_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NEURON_COUNT - 1);

    logic [WORD_W-1:0] mem [NEURON_COUNT];
    logic [WORD_W-1:0] rd_data_reg;
    logic              clr_active_reg;
    logic              clr_active_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // clearing sweep control
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_next = 1'b0;
                clr_addr_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // storage, read returns the old word on a same-edge write
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

`ifndef ASSERT_OFF
    // no neuron update may collide with the clearing sweep
    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en || rd_en) |-> !clr_active_reg)
        else $error("state access during clearing sweep");

    // the sweep ends only after the last entry was cleared
    a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_active_reg) |-> $past(clr_addr_reg) == LAST_ADDR)
        else $error("clearing sweep ended early");
`endif

endmodule

`default_nettype wire

FILE: hdl/alif_update.sv
// alif_update: two-stage read-modify-write datapath for one neuron step
// forwards the last written word, stalls when the next stage writes the same neuron; uses alif_pkg
`default_nettype none

module alif_update #(
    parameter int STATE_WIDTH = alif_pkg::STATE_WIDTH_DEF,
    parameter int ADDR_W      = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire alif_pkg::cfg_t                 cfg,
    input  wire logic                           accept,
    input  wire logic [alif_pkg::IDX_W-1:0]     neuron_index,
    input  wire logic [alif_pkg::CUR_W-1:0]     input_current,
    input  wire logic                           sequence_start,
    input  wire logic [ADDR_W-1:0]              addr,
    input  wire logic [4*STATE_WIDTH:0]         rd_data,
    output logic                                hazard,
    output logic                                wr_en,
    output logic      [ADDR_W-1:0]              wr_addr,
    output logic      [4*STATE_WIDTH:0]         wr_data,
    output logic                                res_valid,
    output alif_pkg::result_t                   res
);
    import alif_pkg::*;

    localparam int SW     = STATE_WIDTH;
    localparam int MW     = 4 * SW + 1;
    localparam int PW     = SW + 17;   // decay product
    localparam int GW     = SW + 16;   // gain product
    localparam int NW     = SW + 3;    // pre-saturation sum
    localparam int TW     = SW + 9;    // threshold
    localparam int SUMX_W = (SW + 1 > SUM_W + 1) ? SW + 1 : SUM_W + 1;
    localparam int V_LSB  = 3 * SW + 1;
    localparam int A_LSB  = 2 * SW + 1;
    localparam int EV_LSB = SW + 1;
    localparam int EA_LSB = 1;

    localparam logic signed [NW-1:0] SAT_HI = {{(NW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [NW-1:0] SAT_LO = {{(NW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [SUMX_W-1:0] TS_HI =
        {{(SUMX_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUMX_W-1:0] TS_LO =
        {{(SUMX_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
    localparam logic signed [NW-1:0] SPIKE_ONE = NW'(256);

    // first stage: read data arrives
    logic              p1_valid_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic [CUR_W-1:0]  p1_cur_reg;
    logic              p1_start_reg;
    logic [ADDR_W-1:0] p1_addr_reg;

    // second stage: products registered
    logic                    p2_valid_reg;
    logic [IDX_W-1:0]        p2_idx_reg;
    logic signed [CUR_W-1:0] p2_cur_reg;
    logic                    p2_prev_reg;
    logic [ADDR_W-1:0]       p2_addr_reg;
    logic signed [PW-1:0]    pv_reg;
    logic signed [PW-1:0]    pa_reg;
    logic signed [PW-1:0]    pev_reg;
    logic signed [PW-1:0]    pea_reg;
    logic signed [GW-1:0]    pg_reg;

    // last written word
    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [MW-1:0]     wb_data_reg;

    logic [MW-1:0]        st;
    logic signed [SW-1:0] st_v;
    logic signed [SW-1:0] st_a;
    logic signed [SW-1:0] st_ev;
    logic signed [SW-1:0] st_ea;
    logic signed [PW-1:0] pv_next;
    logic signed [PW-1:0] pa_next;
    logic signed [PW-1:0] pev_next;
    logic signed [PW-1:0] pea_next;
    logic signed [GW-1:0] pg_next;
    logic                 p1_move;

    logic signed [NW-1:0]     rest_ext;
    logic signed [NW-1:0]     v_sum;
    logic signed [NW-1:0]     a_sum;
    logic signed [NW-1:0]     ev_sum;
    logic signed [NW-1:0]     ea_sum;
    logic signed [SW-1:0]     v_new;
    logic signed [SW-1:0]     a_new;
    logic signed [SW-1:0]     ev_new;
    logic signed [SW-1:0]     ea_new;
    logic signed [TW-1:0]     thr;
    logic                     spk;
    logic signed [SUMX_W-1:0] tsum;
    logic signed [SUM_W-1:0]  tsum_sat;

    function automatic logic signed [SW-1:0] sat_state(input logic signed [NW-1:0] x);
        if (x > SAT_HI)
        begin
            return SAT_HI[SW-1:0];
        end
        else if (x < SAT_LO)
        begin
            return SAT_LO[SW-1:0];
        end
        return x[SW-1:0];
    endfunction

    // a write still in the second stage to the same neuron holds the first stage
    assign hazard  = p1_valid_reg && p2_valid_reg && (p1_addr_reg == p2_addr_reg);
    assign p1_move = p1_valid_reg && !hazard;

    // state select: forward, then start-of-sequence clear
    always_comb
    begin
        st = rd_data;
        if (wb_valid_reg && (wb_addr_reg == p1_addr_reg))
        begin
            st = wb_data_reg;
        end
        if (p1_start_reg)
        begin
            st = '0;
        end
        st_v  = $signed(st[V_LSB  +: SW]);
        st_a  = $signed(st[A_LSB  +: SW]);
        st_ev = $signed(st[EV_LSB +: SW]);
        st_ea = $signed(st[EA_LSB +: SW]);
    end

    // decay and gain products
    assign pv_next  = st_v  * $signed({1'b0, cfg.membrane_decay});
    assign pa_next  = st_a  * $signed({1'b0, cfg.adaptation_decay});
    assign pev_next = st_ev * $signed({1'b0, cfg.membrane_decay});
    assign pea_next = st_ea * $signed({1'b0, cfg.adaptation_decay});
    assign pg_next  = $signed(cfg.adaptation_gain) * st_a;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept || hazard;
            p2_valid_reg <= p1_move;
            wb_valid_reg <= p2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_idx_reg   <= neuron_index;
            p1_cur_reg   <= input_current;
            p1_start_reg <= sequence_start;
            p1_addr_reg  <= addr;
        end
        if (p1_move)
        begin
            p2_idx_reg  <= p1_idx_reg;
            p2_cur_reg  <= $signed(p1_cur_reg);
            p2_prev_reg <= st[0];
            p2_addr_reg <= p1_addr_reg;
            pv_reg      <= pv_next;
            pa_reg      <= pa_next;
            pev_reg     <= pev_next;
            pea_reg     <= pea_next;
            pg_reg      <= pg_next;
        end
        if (p2_valid_reg)
        begin
            wb_addr_reg <= p2_addr_reg;
            wb_data_reg <= wr_data;
        end
    end

    // second stage: floor shift, add, saturate, threshold compare
    always_comb
    begin
        rest_ext = NW'(cfg.rest_threshold);
        v_sum    = NW'($signed(pv_reg[PW-1:16])) + NW'(p2_cur_reg)
                   - (p2_prev_reg ? rest_ext : '0);
        a_sum    = NW'($signed(pa_reg[PW-1:16])) + (p2_prev_reg ? SPIKE_ONE : '0);
        ev_sum   = NW'($signed(pev_reg[PW-1:16])) + NW'(p2_cur_reg);
        v_new    = sat_state(v_sum);
        a_new    = sat_state(a_sum);
        ev_new   = sat_state(ev_sum);
        thr      = TW'(cfg.rest_threshold) + TW'($signed(pg_reg[GW-1:8]));
        spk      = TW'(v_new) > thr;
        ea_sum   = NW'($signed(pea_reg[PW-1:16])) + (spk ? SPIKE_ONE : '0);
        ea_new   = sat_state(ea_sum);
        tsum     = SUMX_W'(ev_new) + SUMX_W'(ea_new);
        if (tsum > TS_HI)
        begin
            tsum_sat = TS_HI[SUM_W-1:0];
        end
        else if (tsum < TS_LO)
        begin
            tsum_sat = TS_LO[SUM_W-1:0];
        end
        else
        begin
            tsum_sat = tsum[SUM_W-1:0];
        end
    end

    // write back and result
    assign wr_en   = p2_valid_reg;
    assign wr_addr = p2_addr_reg;
    assign wr_data = {v_new, a_new, ev_new, ea_new, spk};

    assign res_valid        = p2_valid_reg;
    assign res.neuron_index = p2_idx_reg;
    assign res.spike        = spk;
    assign res.trace_sum    = tsum_sat;

`ifndef ASSERT_OFF
    // a stall inserts a bubble in front of the dependent step
    a_stall_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        hazard |=> !p2_valid_reg)
        else $error("dependent step not separated by a bubble");

    // a stalled step keeps its neuron
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        hazard |=> p1_valid_reg && $stable(p1_addr_reg))
        else $error("stalled step lost its neuron");
`endif

endmodule

`default_nettype wire

FILE: hdl/alif_out_buf.sv
// alif_out_buf: small result queue between the datapath and the result channel
// space is reserved by the top level before an item enters; uses alif_pkg
`default_nettype none

module alif_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire alif_pkg::result_t push_data,
    output logic                   valid,
    input  wire logic              ready,
    output alif_pkg::result_t      data
);
    import alif_pkg::*;

    result_t              slot_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_PTR_W:0]   count_reg;
    logic                 pop;

    assign pop   = valid && ready;
    assign valid = (count_reg != '0);
    assign data  = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + {{OUT_PTR_W{1'b0}}, push} - {{OUT_PTR_W{1'b0}}, pop};
        end
    end

    // result words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    // the reservation upstream keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> count_reg != (OUT_PTR_W+1)'(OUT_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// tb: self-checking bench for alif_neuron_eprop_update, the adaptive LIF neuron step with traces
// predicts every result word in fixed point and drives randomized traffic and idle phases
// depends on hdl/alif_pkg.sv and hdl/alif_neuron_eprop_update.sv
`timescale 1ns / 100ps

module tb;
    import alif_pkg::*;

    localparam int HALF_PERIOD      = 4;
    localparam int QUIET_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SAT_STEPS        = 280;
    localparam int RANDOM_STEPS     = 85;

    // clock, reset and dut ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic [IDX_W-1:0]     neuron_index = '0;
    logic [CUR_W-1:0]     input_current = '0;
    logic                 sequence_start = 1'b0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [IDX_W-1:0]     out_neuron_index;
    logic                 spike;
    logic [SUM_W-1:0]     trace_sum;

    // shadow copy of the registers
    logic        [CFG_W-1:0] membrane_decay_q   = MEMBRANE_DECAY_RST;
    logic        [CFG_W-1:0] adaptation_decay_q = ADAPTATION_DECAY_RST;
    logic signed [CFG_W-1:0] adaptation_gain_q  = ADAPTATION_GAIN_RST;
    logic signed [CFG_W-1:0] rest_threshold_q   = REST_THRESHOLD_RST;

    // shadow copy of the per-neuron state, zero after reset
    longint potential_q       [NEURON_COUNT_DEF];
    longint adaptation_q      [NEURON_COUNT_DEF];
    longint potential_trace_q [NEURON_COUNT_DEF];
    longint adapt_trace_q     [NEURON_COUNT_DEF];
    bit     last_spike_q      [NEURON_COUNT_DEF];

    result_t neuron_results_due [$];

    int mismatch_count  = 0;
    int quiet_cycles    = 0;
    int stall_hold_left = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    alif_neuron_eprop_update dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .neuron_index     (neuron_index),
        .input_current    (input_current),
        .sequence_start   (sequence_start),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .out_neuron_index (out_neuron_index),
        .spike            (spike),
        .trace_sum        (trace_sum)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // saturate a signed value to the given width
    function automatic longint clamp_to_width(input longint x, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // multiply by an unsigned Q0.16 factor, floor toward minus infinity
    function automatic longint scale_by_decay(input longint x, input logic [CFG_W-1:0] f);
        return (x * longint'({48'd0, f})) >>> 16;
    endfunction

    // one neuron step on the shadow state, returns the word the dut must produce
    function automatic result_t predict_neuron_step(input logic [IDX_W-1:0] idx,
                                                    input logic [CUR_W-1:0] cur_bits,
                                                    input logic start);
        int      n;
        longint  cur, gain, rest, v, a, ev, ea, thr, sum;
        bit      prev, fired;
        result_t r;
        n    = int'(idx) % NEURON_COUNT_DEF;
        cur  = longint'($signed(cur_bits));
        gain = longint'(adaptation_gain_q);
        rest = longint'(rest_threshold_q);
        if (start)
        begin
            potential_q[n]       = 0;
            adaptation_q[n]      = 0;
            potential_trace_q[n] = 0;
            adapt_trace_q[n]     = 0;
            last_spike_q[n]      = 1'b0;
        end
        v    = potential_q[n];
        a    = adaptation_q[n];
        ev   = potential_trace_q[n];
        ea   = adapt_trace_q[n];
        prev = last_spike_q[n];
        // threshold from the old adaptation, full precision
        thr  = rest + ((gain * a) >>> 8);
        v    = clamp_to_width(scale_by_decay(v, membrane_decay_q) + cur
                              - (prev ? rest : 64'sd0), STATE_WIDTH_DEF);
        a    = clamp_to_width(scale_by_decay(a, adaptation_decay_q)
                              + (prev ? 64'sd256 : 64'sd0), STATE_WIDTH_DEF);
        fired = (v > thr);
        ev   = clamp_to_width(scale_by_decay(ev, membrane_decay_q) + cur, STATE_WIDTH_DEF);
        ea   = clamp_to_width(scale_by_decay(ea, adaptation_decay_q)
                              + (fired ? 64'sd256 : 64'sd0), STATE_WIDTH_DEF);
        potential_q[n]       = v;
        adaptation_q[n]      = a;
        potential_trace_q[n] = ev;
        adapt_trace_q[n]     = ea;
        last_spike_q[n]      = fired;
        sum = clamp_to_width(ev + ea, SUM_W);
        r.neuron_index = idx;
        r.spike        = fired;
        r.trace_sum    = sum[SUM_W-1:0];
        return r;
    endfunction

    // compare one accepted result word with the oldest prediction
    function automatic void check_result_word();
        result_t want;
        if (neuron_results_due.size() == 0)
        begin
            $display("%0t: unexpected result word, index %0d spike %0d sum %0d",
                     $time, out_neuron_index, spike, $signed(trace_sum));
            mismatch_count++;
            return;
        end
        want = neuron_results_due.pop_front();
        if (want.neuron_index !== out_neuron_index)
        begin
            $display("%0t: neuron index expected %0d, got %0d",
                     $time, want.neuron_index, out_neuron_index);
            mismatch_count++;
        end
        if (want.spike !== spike)
        begin
            $display("%0t: spike of neuron %0d expected %0d, got %0d",
                     $time, want.neuron_index, want.spike, spike);
            mismatch_count++;
        end
        if (want.trace_sum !== trace_sum)
        begin
            $display("%0t: trace sum of neuron %0d expected %0d, got %0d",
                     $time, want.neuron_index, $signed(want.trace_sum), $signed(trace_sum));
            mismatch_count++;
        end
    endfunction

    // result side: check accepted words, then pick next ready
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
                check_result_word();
            result_ready <= (stall_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off countdown
    always @(posedge clk)
    begin
        if (stall_hold_left > 0)
            stall_hold_left <= stall_hold_left - 1;
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one step word, return in the cycle it is accepted
    task automatic send_step(input logic [IDX_W-1:0] idx, input logic [CUR_W-1:0] cur,
                             input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid     <= 1'b1;
        neuron_index   <= idx;
        input_current  <= cur;
        sequence_start <= start;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        neuron_results_due.push_back(predict_neuron_step(idx, cur, start));
    endtask

    // setup and access cycle of one register write, psel left high
    task automatic write_register(input reg_idx_t r, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (r)
            REG_MEMBRANE_DECAY:   membrane_decay_q   = value;
            REG_ADAPTATION_DECAY: adaptation_decay_q = value;
            REG_ADAPTATION_GAIN:  adaptation_gain_q  = value;
            REG_REST_THRESHOLD:   rest_threshold_q   = value;
        endcase
    endtask

    // drain the block, then write all four registers
    task automatic apply_settings(input logic [CFG_W-1:0] md, input logic [CFG_W-1:0] ad,
                                  input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] rest);
        item_valid <= 1'b0;
        do @(posedge clk); while (neuron_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(REG_MEMBRANE_DECAY, md);
        write_register(REG_ADAPTATION_DECAY, ad);
        write_register(REG_ADAPTATION_GAIN, gain);
        write_register(REG_REST_THRESHOLD, rest);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly moderate currents, some full range and extremes
    function automatic logic [CUR_W-1:0] pick_current();
        int c;
        case ($urandom_range(9))
            0:       c = int'($urandom);
            1:       c = ($urandom_range(1) == 1) ? 32767 : -32768;
            default: c = int'($urandom_range(900)) - 200;
        endcase
        return c[CUR_W-1:0];
    endfunction

    // fresh neuron, max and min current, one step right after the start
    task automatic short_burst(input logic [IDX_W-1:0] idx);
        send_step(idx, 16'h7FFF, 1'b1);
        send_step(idx, 16'h7FFF, 1'b0);
        send_step(idx, 16'h8000, 1'b0);
        send_step(idx, 16'h0001, 1'b0);
    endtask

    // reset settings: threshold edge, spike aftermath, field extremes
    task automatic test_default_steps();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_step(8'd0, 16'h0000, 1'b1);
        // potential equal to threshold does not fire
        send_step(8'd0, 16'h0100, 1'b0);
        // just above threshold fires
        send_step(8'd1, 16'h0101, 1'b1);
        // previous spike: reset subtraction and adaptation step
        send_step(8'd1, 16'h0000, 1'b0);
        send_step(8'd1, 16'h7FFF, 1'b0);
        send_step(8'd1, 16'h7FFF, 1'b0);
        send_step(8'd1, 16'h8000, 1'b0);
        send_step(8'd255, 16'h8000, 1'b1);
        send_step(8'd255, 16'hFFFF, 1'b0);
        send_step(8'd128, 16'h0001, 1'b1);
        send_step(8'd85, 16'h5555, 1'b1);
        send_step(8'd170, 16'hAAAA, 1'b0);
        // restart a neuron that holds state
        send_step(8'd1, 16'h0200, 1'b1);
        send_step(8'd255, 16'h7FFF, 1'b0);
    endtask

    // register extremes: zero and full decay, min and max gain and threshold
    task automatic test_register_extremes();
        apply_settings(16'h0000, 16'h0000, 16'h8000, 16'h8000);
        short_burst(8'd10);
        apply_settings(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        short_burst(8'd11);
        apply_settings(16'hFFFF, 16'h0000, 16'h8000, 16'h0000);
        short_burst(8'd12);
    endtask

    // slowest decay, two neurons driven into positive and negative saturation
    task automatic test_saturation();
        logic [IDX_W-1:0] up_idx;
        logic [IDX_W-1:0] down_idx;
        int               k;
        apply_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000);
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        up_idx   = 8'($urandom);
        down_idx = up_idx ^ 8'h80;
        for (k = 0; k < SAT_STEPS; k++)
        begin
            send_step(up_idx, 16'h7FFF - 16'($urandom_range(255)), k == 0);
            send_step(down_idx, 16'h8000, k == 0);
        end
    endtask

    // random settings per idle phase, interleaved neuron sequences plus noise
    task automatic test_random_traffic();
        logic [IDX_W-1:0] pool [6];
        bit               started [6];
        logic [CFG_W-1:0] md, ad;
        int               phase, k, p, g, r;
        logic             start;
        for (phase = 0; phase < 4; phase++)
        begin
            md = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(65535 - $urandom_range(4000));
            ad = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(65535 - $urandom_range(500));
            g  = ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(1024)) - 256;
            r  = ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(768)) - 128;
            apply_settings(md, ad, g[CFG_W-1:0], r[CFG_W-1:0]);
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (p = 0; p < 6; p++)
            begin
                pool[p]    = 8'($urandom);
                started[p] = 1'b0;
            end
            for (k = 0; k < RANDOM_STEPS; k++)
            begin
                if ($urandom_range(15) == 0)
                    send_step(8'($urandom), 16'($urandom), 1'($urandom));
                else
                begin
                    p          = $urandom_range(5);
                    start      = !started[p] || ($urandom_range(24) == 0);
                    started[p] = 1'b1;
                    send_step(pool[p], pick_current(), start);
                end
            end
        end
    endtask

    // receiver holds off for a long stretch while steps keep coming
    task automatic test_output_backpressure();
        logic [IDX_W-1:0] pool [3];
        int               k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (k = 0; k < 3; k++)
            pool[k] = 8'($urandom);
        stall_hold_left <= LONG_HOLD_CYCLES;
        for (k = 0; k < 40; k++)
            send_step(pool[$urandom_range(2)], pick_current(), 1'b0);
    endtask

    // test sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_default_steps();
        test_register_extremes();
        test_saturation();
        test_random_traffic();
        test_output_backpressure();
        item_valid <= 1'b0;
        while (neuron_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
